// ===== rtl/core/sdq_pkg.sv =====
// Shared types and constants for the shape record deque.
`default_nettype none

package sdq_pkg;

  // Field widths of one record and of the result.
  localparam int unsigned COORD_W = 16;
  localparam int unsigned SIDE_W  = 16;
  localparam int unsigned AREA_W  = 32;
  localparam int unsigned FILL_W  = 5;

  // Packed record layout in the two stores.
  localparam int unsigned POS_W  = 2 * COORD_W;
  localparam int unsigned SIZE_W = 2 * SIDE_W + 1;

  // Request codes.
  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Shape kinds.
  localparam logic SHAPE_TRIANGLE = 1'b0;

  // Request summary handed from the ring control to the result stage.
  typedef struct packed {
    logic              valid;
    logic              pop_hit;
    status_e           status;
    logic [FILL_W-1:0] fill;
  } req_t;

endpackage

`default_nettype wire

// ===== rtl/core/sdq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module sdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sdq_ctrl.sv =====
// Ring control: head index, entry count and slot selection for each request.
`default_nettype none

module sdq_ctrl import sdq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire op_e                         op_i,
  output logic                             we_o,
  output logic                             re_o,
  output logic [$clog2(CAPACITY)-1:0]      slot_o,
  output req_t                             req_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  req_t             req_q, req_d;

  logic             full;
  logic             empty;
  logic [SUM_W-1:0] sum_back;
  logic [SUM_W-1:0] sum_last;
  logic [IDX_W-1:0] slot_back;
  logic [IDX_W-1:0] slot_last;
  logic [IDX_W-1:0] head_dec;
  logic [IDX_W-1:0] head_inc;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  // Ring arithmetic: the sums stay below twice the capacity, so one
  // compare and subtract wraps them.
  assign sum_back  = SUM_W'(head_q) + SUM_W'(count_q);
  assign sum_last  = sum_back - SUM_W'(1);
  assign slot_back = (sum_back >= SUM_W'(CAPACITY)) ?
                     IDX_W'(sum_back - SUM_W'(CAPACITY)) : IDX_W'(sum_back);
  assign slot_last = (sum_last >= SUM_W'(CAPACITY)) ?
                     IDX_W'(sum_last - SUM_W'(CAPACITY)) : IDX_W'(sum_last);
  assign head_dec  = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - IDX_W'(1);
  assign head_inc  = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + IDX_W'(1);

  // Request decode: store access, pointer update and result summary.
  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    we_o         = 1'b0;
    re_o         = 1'b0;
    slot_o       = slot_back;
    req_d.valid   = accept_i;
    req_d.pop_hit = 1'b0;
    req_d.status  = ST_DONE;
    if (accept_i) begin
      unique case (op_i)
        OP_PUSH_BACK: begin
          if (full) begin
            req_d.status = ST_FULL;
          end else begin
            we_o    = 1'b1;
            slot_o  = slot_back;
            count_d = count_q + CNT_W'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            req_d.status = ST_FULL;
          end else begin
            we_o    = 1'b1;
            slot_o  = head_dec;
            head_d  = head_dec;
            count_d = count_q + CNT_W'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            req_d.status = ST_EMPTY;
          end else begin
            re_o          = 1'b1;
            slot_o        = head_q;
            head_d        = head_inc;
            count_d       = count_q - CNT_W'(1);
            req_d.pop_hit = 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            req_d.status = ST_EMPTY;
          end else begin
            re_o          = 1'b1;
            slot_o        = slot_last;
            count_d       = count_q - CNT_W'(1);
            req_d.pop_hit = 1'b1;
          end
        end
        default: begin
          req_d.status = ST_DONE;
        end
      endcase
    end
    req_d.fill = FILL_W'(count_d);
  end

  // Pointer and request stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      req_q   <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      req_q   <= req_d;
    end
  end

  assign req_o = req_q;

endmodule

`default_nettype wire

// ===== rtl/core/sdq_result.sv =====
// Result stage: unpacks the popped record, computes its area and registers the result.
`default_nettype none

module sdq_result import sdq_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire req_t                req_i,
  input  wire logic [POS_W-1:0]    pos_i,
  input  wire logic [SIZE_W-1:0]   size_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic                     out_shape_o,
  output logic signed [COORD_W-1:0] out_x_o,
  output logic signed [COORD_W-1:0] out_y_o,
  output logic [SIDE_W-1:0]        out_side_a_o,
  output logic [SIDE_W-1:0]        out_side_b_o,
  output logic [AREA_W-1:0]        out_area_o,
  output logic [FILL_W-1:0]        fill_count_o
);

  logic              shape;
  logic [SIDE_W-1:0] side_a;
  logic [SIDE_W-1:0] side_b;
  logic [AREA_W-1:0] product;
  logic [AREA_W-1:0] area;

  // Unpack the record and form the area; a triangle halves the product.
  assign shape   = size_i[SIZE_W-1];
  assign side_a  = size_i[2*SIDE_W-1:SIDE_W];
  assign side_b  = size_i[SIDE_W-1:0];
  assign product = AREA_W'(side_a) * AREA_W'(side_b);
  assign area    = (shape == SHAPE_TRIANGLE) ? (product >> 1) : product;

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= req_i.valid;
    end
  end

  // Result payload; record fields read as zero unless a pop found a record.
  always_ff @(posedge clk_i) begin
    status_o     <= req_i.status;
    fill_count_o <= req_i.fill;
    if (req_i.pop_hit) begin
      out_shape_o  <= shape;
      out_x_o      <= pos_i[POS_W-1:COORD_W];
      out_y_o      <= pos_i[COORD_W-1:0];
      out_side_a_o <= side_a;
      out_side_b_o <= side_b;
      out_area_o   <= area;
    end else begin
      out_shape_o  <= 1'b0;
      out_x_o      <= '0;
      out_y_o      <= '0;
      out_side_a_o <= '0;
      out_side_b_o <= '0;
      out_area_o   <= '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/shape_record_deque.sv =====
// Top level of the shape record deque: ring control, record stores and result stage.
//
//   Channel   Handshake          Ports
//   --------  -----------------  ----------------------------------------------
//   request   start_i & !busy_o  kind_i, shape_kind_i, pos_x_i, pos_y_i,
//                                side_a_i, side_b_i
//   result    done_o (1 cycle)   status_o, out_shape_o, out_x_o, out_y_o,
//                                out_side_a_o, out_side_b_o, out_area_o,
//                                fill_count_o
//
// Each request gives one result: the store read and the request summary are
// registered when it is taken, then the result stage registers the area.
// A new request may be taken at every edge, so busy_o stays low; the pointers
// update at the accepting edge, and an entry written there is read back by a
// later pop from the RAM itself. The result receiver cannot stall, and each
// result stands for exactly one cycle. Reset clears the pointers and the
// strobe; the stores need no clearing, since pops only read written entries.
`default_nettype none

module shape_record_deque import sdq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [1:0]           kind_i,
  input  wire logic                 shape_kind_i,
  input  wire logic signed [COORD_W-1:0] pos_x_i,
  input  wire logic signed [COORD_W-1:0] pos_y_i,
  input  wire logic [SIDE_W-1:0]    side_a_i,
  input  wire logic [SIDE_W-1:0]    side_b_i,
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic                      out_shape_o,
  output logic signed [COORD_W-1:0] out_x_o,
  output logic signed [COORD_W-1:0] out_y_o,
  output logic [SIDE_W-1:0]         out_side_a_o,
  output logic [SIDE_W-1:0]         out_side_b_o,
  output logic [AREA_W-1:0]         out_area_o,
  output logic [FILL_W-1:0]         fill_count_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);

  logic              accept;
  logic              we;
  logic              re;
  logic [IDX_W-1:0]  slot;
  req_t              req;
  logic [POS_W-1:0]  pos_wdata;
  logic [SIZE_W-1:0] size_wdata;
  logic [POS_W-1:0]  pos_rdata;
  logic [SIZE_W-1:0] size_rdata;

  // The pipeline takes a transaction at every edge.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Record packing for the two stores.
  assign pos_wdata  = {pos_x_i, pos_y_i};
  assign size_wdata = {shape_kind_i, side_a_i, side_b_i};

  sdq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (op_e'(kind_i)),
    .we_o     (we),
    .re_o     (re),
    .slot_o   (slot),
    .req_o    (req)
  );

  sdq_ram #(
    .WIDTH (POS_W),
    .DEPTH (CAPACITY)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot),
    .wdata_i (pos_wdata),
    .re_i    (re),
    .raddr_i (slot),
    .rdata_o (pos_rdata)
  );

  sdq_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (CAPACITY)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot),
    .wdata_i (size_wdata),
    .re_i    (re),
    .raddr_i (slot),
    .rdata_o (size_rdata)
  );

  sdq_result u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .pos_i        (pos_rdata),
    .size_i       (size_rdata),
    .done_o       (done_o),
    .status_o     (status_o),
    .out_shape_o  (out_shape_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_side_a_o (out_side_a_o),
    .out_side_b_o (out_side_b_o),
    .out_area_o   (out_area_o),
    .fill_count_o (fill_count_o)
  );

  // Every accepted transaction yields a result on done_o.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("accepted transaction produced no result");

  // A refused push reports a full store.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (fill_count_o == FILL_W'(CAPACITY)))
    else $error("full status with a store that is not full");

  // A pop that finds nothing reports an empty store and no record.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> (fill_count_o == '0 && out_area_o == '0))
    else $error("empty status with stored records or record data");

endmodule

`default_nettype wire
